### rtl/shd_pkg.sv
// shd_pkg: shared types, codes and calendar helpers for the solar hijri day counter
// no dependencies; imported by shd_check, shd_step and solar_hijri_days_between_unit
`default_nettype none

package shd_pkg;

	localparam int unsigned YearMax   = 4095;
	localparam int unsigned DayW      = 5;
	localparam int unsigned MonthW    = 4;
	localparam int unsigned YearW     = 12;
	localparam int unsigned CountW    = 21;
	localparam int unsigned RemW      = 6;
	localparam int unsigned CycleLast = 32;

	// bit r set when year mod 33 == r is a leap year
	localparam logic [32:0] LeapMask = 33'h0_4442_2222;

	localparam logic [1:0] ORD_EARLIER = 2'd0;
	localparam logic [1:0] ORD_EQUAL   = 2'd1;
	localparam logic [1:0] ORD_LATER   = 2'd2;

	localparam logic [MonthW-1:0] MonthFirst = 4'd1;
	localparam logic [MonthW-1:0] MonthLast  = 4'd12;

	typedef struct packed {
		logic [YearW-1:0]  year;
		logic [MonthW-1:0] month;
		logic [DayW-1:0]   day;
	} date_t;

	typedef struct packed {
		logic             ok;
		logic [1:0]       order;
		date_t            early;
		date_t            late;
		logic [RemW-1:0]  early_rem;
	} chk_res_t;

	function automatic logic is_leap(input logic [RemW-1:0] rem);
		return LeapMask[rem];
	endfunction

	function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
			input logic leap);
		logic [DayW-1:0] len;
		if (m < 4'd7)
			len = 5'd31;
		else if (m < MonthLast)
			len = 5'd30;
		else
			len = leap ? 5'd30 : 5'd29;
		return len;
	endfunction

	// year mod 33 by reciprocal multiply, exact for 12-bit years
	function automatic logic [RemW-1:0] mod33(input logic [YearW-1:0] y);
		logic [21:0]      p;
		logic [6:0]       q;
		logic [YearW-1:0] qm;
		logic [YearW-1:0] r;
		p  = 22'(y) * 22'd993;
		q  = p[21:15];
		qm = 12'(q) * 12'd33;
		r  = y - qm;
		return r[RemW-1:0];
	endfunction

endpackage

`default_nettype wire

### rtl/shd_check.sv
// shd_check: validates two dates, orders them and finds the cycle position of the earlier year
// depends on shd_pkg
`default_nettype none

module shd_check
	import shd_pkg::*;
(
	input  wire date_t    a,
	input  wire date_t    b,
	output chk_res_t      res
);

	logic [RemW-1:0] rem_a;
	logic [RemW-1:0] rem_b;
	logic            ok_a;
	logic            ok_b;
	logic            a_lt_b;
	logic            a_eq_b;

	assign rem_a = mod33(a.year);
	assign rem_b = mod33(b.year);

	assign ok_a = (32'(a.year) <= YearMax) && (a.month >= MonthFirst) &&
		(a.month <= MonthLast) && (a.day != '0) &&
		(a.day <= month_len(a.month, is_leap(rem_a)));
	assign ok_b = (32'(b.year) <= YearMax) && (b.month >= MonthFirst) &&
		(b.month <= MonthLast) && (b.day != '0) &&
		(b.day <= month_len(b.month, is_leap(rem_b)));

	// valid dates order the same way as their packed year/month/day
	assign a_lt_b = a < b;
	assign a_eq_b = a == b;

	always_comb begin
		res.ok = ok_a && ok_b;
		if (!res.ok)
			res.order = ORD_EARLIER;
		else if (a_lt_b)
			res.order = ORD_EARLIER;
		else if (a_eq_b)
			res.order = ORD_EQUAL;
		else
			res.order = ORD_LATER;
		if (a_lt_b || a_eq_b) begin
			res.early     = a;
			res.late      = b;
			res.early_rem = rem_a;
		end else begin
			res.early     = b;
			res.late      = a;
			res.early_rem = rem_b;
		end
	end

endmodule

`default_nettype wire

### rtl/shd_step.sv
// shd_step: advances a date by one day, carrying the year position in the 33-year cycle
// depends on shd_pkg
`default_nettype none

module shd_step
	import shd_pkg::*;
(
	input  wire date_t           cur,
	input  wire [RemW-1:0]       rem,
	output date_t                nxt,
	output logic [RemW-1:0]      nxt_rem
);

	logic [DayW-1:0] len;

	assign len = month_len(cur.month, is_leap(rem));

	always_comb begin
		nxt     = cur;
		nxt_rem = rem;
		if (cur.day == len) begin
			nxt.day = 5'd1;
			if (cur.month == MonthLast) begin
				nxt.month = MonthFirst;
				nxt.year  = cur.year + 12'd1;
				nxt_rem   = (rem == RemW'(CycleLast)) ? '0 : rem + 6'd1;
			end else begin
				nxt.month = cur.month + 4'd1;
			end
		end else begin
			nxt.day = cur.day + 5'd1;
		end
	end

endmodule

`default_nettype wire

### rtl/solar_hijri_days_between_unit.sv
// solar_hijri_days_between_unit: top level, sequencer around the one-day step unit
// depends on shd_pkg, shd_check, shd_step
//
//   channel   handshake        fields
//   request   start / busy     first_day, first_month, first_year,
//                              second_day, second_month, second_year
//   result    done (strobe)    day_count, order, invalid
//
// a beat is taken when start is high and busy is low; busy then stays high
// while the check state checks and orders the dates, then the step unit walks the
// earlier date forward one day per cycle until it reaches the later date; invalid
// or equal dates go straight back to idle from the check state, with no walk
// done pulses for one cycle with the result; the receiver cannot stall
// arst_n clears the sequencer and the strobe; no clearing pass is needed
`default_nettype none

module solar_hijri_days_between_unit
	import shd_pkg::*;
(
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  wire [DayW-1:0]      first_day,
	input  wire [MonthW-1:0]    first_month,
	input  wire [YearW-1:0]     first_year,
	input  wire [DayW-1:0]      second_day,
	input  wire [MonthW-1:0]    second_month,
	input  wire [YearW-1:0]     second_year,
	output logic                done,
	output logic [CountW-1:0]   day_count,
	output logic [1:0]          order,
	output logic                invalid
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_RUN
	} state_t;

	state_t            state_q;
	date_t             a_q;
	date_t             b_q;
	date_t             cursor_q;
	date_t             target_q;
	logic [RemW-1:0]   rem_q;
	logic [CountW-1:0] count_q;
	logic [1:0]        order_q;
	logic              done_q;
	logic [CountW-1:0] day_count_q;
	logic [1:0]        res_order_q;
	logic              invalid_q;

	chk_res_t          chk;
	date_t             step_nxt;
	logic [RemW-1:0]   step_rem;
	logic              accept;

	shd_check u_check (
		.a   (a_q),
		.b   (b_q),
		.res (chk)
	);

	shd_step u_step (
		.cur     (cursor_q),
		.rem     (rem_q),
		.nxt     (step_nxt),
		.nxt_rem (step_rem)
	);

	assign busy      = state_q != ST_IDLE;
	assign accept    = start && !busy;
	assign done      = done_q;
	assign day_count = day_count_q;
	assign order     = res_order_q;
	assign invalid   = invalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (!chk.ok || chk.order == ORD_EQUAL) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cursor_q == target_q) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload path, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					a_q <= '{year: first_year, month: first_month, day: first_day};
					b_q <= '{year: second_year, month: second_month, day: second_day};
				end
			end
			ST_CHECK: begin
				cursor_q <= chk.early;
				target_q <= chk.late;
				rem_q    <= chk.early_rem;
				count_q  <= CountW'(1);
				order_q  <= chk.order;
				if (!chk.ok) begin
					day_count_q <= '0;
					res_order_q <= ORD_EARLIER;
					invalid_q   <= 1'b1;
				end else if (chk.order == ORD_EQUAL) begin
					day_count_q <= CountW'(1);
					res_order_q <= ORD_EQUAL;
					invalid_q   <= 1'b0;
				end
			end
			ST_RUN: begin
				if (cursor_q == target_q) begin
					day_count_q <= count_q;
					res_order_q <= order_q;
					invalid_q   <= 1'b0;
				end else begin
					cursor_q <= step_nxt;
					rem_q    <= step_rem;
					count_q  <= count_q + CountW'(1);
				end
			end
			default: ;
		endcase
	end

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without an item in flight");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && invalid |-> day_count == '0 && order == ORD_EARLIER)
		else $error("invalid result carries a count or order");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("accepted beat did not make the unit busy");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !invalid |-> day_count != '0)
		else $error("valid result with zero count");

endmodule

`default_nettype wire

### tb/sv/solar_hijri_days_between_unit_tb.sv
// solar_hijri_days_between_unit_tb: self-checking bench for the solar hijri day counter
// directed table then random date pairs, checked against pinned rows or a day-serial predictor
// depends on shd_pkg and solar_hijri_days_between_unit

module solar_hijri_days_between_unit_tb;
	import shd_pkg::*;

	localparam int unsigned RESET_CYCLES   = 11;
	localparam int unsigned RANDOM_ITEMS   = 100;
	localparam int unsigned DRAIN_EVERY    = 30;
	localparam int unsigned TAIL_CYCLES    = 8;
	// longest item here is the walk from year 0 to year 1500, shorter than a full-range walk
	localparam int unsigned WATCHDOG_LIMIT = 3_000_000;
	localparam int unsigned DIR_ROWS       = 20;

	typedef struct packed {
		logic [DayW-1:0]   d1;
		logic [MonthW-1:0] m1;
		logic [YearW-1:0]  y1;
		logic [DayW-1:0]   d2;
		logic [MonthW-1:0] m2;
		logic [YearW-1:0]  y2;
	} date_pair_t;

	typedef struct packed {
		logic [CountW-1:0] count;
		logic [1:0]        order;
		logic              invalid;
	} span_res_t;

	typedef struct packed {
		date_pair_t pair;
		logic       pinned;
		span_res_t  res;
	} dir_row_t;

	typedef enum int unsigned {
		FAULT_DAY_ZERO,
		FAULT_DAY_OVER,
		FAULT_MONTH_ZERO,
		FAULT_MONTH_HIGH
	} date_fault_t;

	localparam span_res_t BAD_DATE  = '{'0, ORD_EARLIER, 1'b1};
	localparam span_res_t NOT_TYPED = '0;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	date_pair_t drv_pair = '0;
	logic drv_pinned = 1'b0;
	span_res_t drv_pinned_res = '0;

	logic busy;
	logic done;
	logic [CountW-1:0] day_count;
	logic [1:0] order;
	logic invalid;

	span_res_t expected_spans[$];
	dir_row_t dir_rows[DIR_ROWS];
	int unsigned items_taken = 0;
	int unsigned invalid_taken = 0;
	int unsigned results_checked = 0;
	int unsigned mismatches = 0;
	int unsigned longest_span = 0;
	int unsigned idle_cycles = 0;
	int unsigned burst_left = 0;

	solar_hijri_days_between_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.first_day    (drv_pair.d1),
		.first_month  (drv_pair.m1),
		.first_year   (drv_pair.y1),
		.second_day   (drv_pair.d2),
		.second_month (drv_pair.m2),
		.second_year  (drv_pair.y2),
		.done         (done),
		.day_count    (day_count),
		.order        (order),
		.invalid      (invalid)
	);

	always #2 clk = ~clk;

	function automatic logic leap_year(input logic [YearW-1:0] y);
		case (y % 33)
			1, 5, 9, 13, 17, 22, 26, 30: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic int unsigned month_days(input logic [MonthW-1:0] m,
			input logic [YearW-1:0] y);
		if (m < 7)
			return 31;
		if (m < MonthLast)
			return 30;
		return leap_year(y) ? 30 : 29;
	endfunction

	function automatic logic date_valid(input logic [DayW-1:0] d, input logic [MonthW-1:0] m,
			input logic [YearW-1:0] y);
		if (y > YearMax || m < MonthFirst || m > MonthLast)
			return 1'b0;
		return d != 0 && d <= month_days(m, y);
	endfunction

	// days since 1/1/0
	function automatic int unsigned day_serial(input logic [DayW-1:0] d,
			input logic [MonthW-1:0] m, input logic [YearW-1:0] y);
		int unsigned s;
		s = y * 365 + (y / 33) * 8;
		for (int unsigned i = 0; i < y % 33; i++)
			s += leap_year(YearW'(i));
		if (m > 6)
			s += 6 * 31 + (m - 7) * 30;
		else
			s += (m - 1) * 31;
		return s + d - 1;
	endfunction

	function automatic span_res_t predict_span(input date_pair_t q);
		int unsigned s1;
		int unsigned s2;
		span_res_t r;
		if (!date_valid(q.d1, q.m1, q.y1) || !date_valid(q.d2, q.m2, q.y2))
			return BAD_DATE;
		s1 = day_serial(q.d1, q.m1, q.y1);
		s2 = day_serial(q.d2, q.m2, q.y2);
		r.invalid = 1'b0;
		if (s1 < s2) begin
			r.order = ORD_EARLIER;
			r.count = CountW'(s2 - s1 + 1);
		end else if (s1 == s2) begin
			r.order = ORD_EQUAL;
			r.count = CountW'(1);
		end else begin
			r.order = ORD_LATER;
			r.count = CountW'(s1 - s2 + 1);
		end
		return r;
	endfunction

	function automatic date_pair_t random_pair();
		date_pair_t q;
		int unsigned kind;
		int yr;
		logic [DayW-1:0] d;
		logic [MonthW-1:0] m;
		logic [YearW-1:0] y;
		logic hit_second;
		kind = $urandom_range(0, 99);
		q.y1 = YearW'($urandom_range(0, YearMax));
		q.m1 = MonthW'($urandom_range(1, 12));
		q.d1 = DayW'($urandom_range(1, month_days(q.m1, q.y1)));
		if (kind < 15) begin
			q.d2 = q.d1;
			q.m2 = q.m1;
			q.y2 = q.y1;
		end else begin
			if (kind < 35)
				yr = int'(q.y1);
			else if (kind < 92)
				yr = int'(q.y1) + int'($urandom_range(0, 2)) - 1;
			else
				yr = int'(q.y1) + int'($urandom_range(0, 16)) - 8;
			if (yr < 0)
				yr = 0;
			if (yr > int'(YearMax))
				yr = int'(YearMax);
			q.y2 = YearW'(yr);
			q.m2 = MonthW'($urandom_range(1, 12));
			q.d2 = DayW'($urandom_range(1, month_days(q.m2, q.y2)));
		end
		// about one pair in ten carries a broken date on one side
		if ($urandom_range(0, 9) == 0) begin
			hit_second = 1'($urandom_range(0, 1));
			d = hit_second ? q.d2 : q.d1;
			m = hit_second ? q.m2 : q.m1;
			y = hit_second ? q.y2 : q.y1;
			case (date_fault_t'($urandom_range(0, 3)))
				FAULT_DAY_ZERO: d = '0;
				FAULT_DAY_OVER: begin
					m = MonthW'($urandom_range(7, 12));
					d = DayW'($urandom_range(month_days(m, y) + 1, 31));
				end
				FAULT_MONTH_ZERO: m = '0;
				default: m = MonthW'($urandom_range(13, 15));
			endcase
			if (hit_second) begin
				q.d2 = d;
				q.m2 = m;
				q.y2 = y;
			end else begin
				q.d1 = d;
				q.m1 = m;
				q.y1 = y;
			end
		end
		return q;
	endfunction

	// raise start with a new beat and wait for the edge that takes it
	task automatic offer(input date_pair_t q, input logic pin, input span_res_t res);
		start <= 1'b1;
		drv_pair <= q;
		drv_pinned <= pin;
		drv_pinned_res <= res;
		do
			@(posedge clk);
		while (busy !== 1'b0);
	endtask

	// sender bursts: back-to-back beats, then a random gap
	task automatic pace();
		int unsigned gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 6);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(0, 1) ? $urandom_range(1, 6) : $urandom_range(10, 25);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (expected_spans.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		span_res_t want;
		if (arst_n) begin
			if (start && !busy) begin
				want = drv_pinned ? drv_pinned_res : predict_span(drv_pair);
				expected_spans.push_back(want);
				items_taken++;
				if (want.invalid)
					invalid_taken++;
				if (want.count > longest_span)
					longest_span = want.count;
			end
			if (done) begin
				if (expected_spans.size() == 0) begin
					$display("%0t: result with nothing expected: day_count %0d order %0d invalid %0b",
						$time, day_count, order, invalid);
					mismatches++;
				end else begin
					want = expected_spans.pop_front();
					results_checked++;
					if (day_count !== want.count) begin
						$display("%0t: day_count expected %0d got %0d", $time, want.count, day_count);
						mismatches++;
					end
					if (order !== want.order) begin
						$display("%0t: order expected %0d got %0d", $time, want.order, order);
						mismatches++;
					end
					if (invalid !== want.invalid) begin
						$display("%0t: invalid expected %0b got %0b", $time, want.invalid, invalid);
						mismatches++;
					end
				end
			end
			if ((start && !busy) || done)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no beat for %0d cycles, %0d results outstanding", $time,
					idle_cycles, expected_spans.size());
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		dir_rows = '{
			'{'{5'd1, 4'd1, 12'd0, 5'd1, 4'd1, 12'd0}, 1'b1, '{21'd1, ORD_EQUAL, 1'b0}},
			'{'{5'd1, 4'd1, 12'd0, 5'd2, 4'd1, 12'd0}, 1'b1, '{21'd2, ORD_EARLIER, 1'b0}},
			'{'{5'd2, 4'd1, 12'd0, 5'd1, 4'd1, 12'd0}, 1'b1, '{21'd2, ORD_LATER, 1'b0}},
			'{'{5'd0, 4'd1, 12'd10, 5'd1, 4'd1, 12'd10}, 1'b1, BAD_DATE},
			'{'{5'd1, 4'd1, 12'd10, 5'd31, 4'd7, 12'd10}, 1'b1, BAD_DATE},
			'{'{5'd1, 4'd0, 12'd10, 5'd1, 4'd1, 12'd10}, 1'b1, BAD_DATE},
			'{'{5'd1, 4'd13, 12'd10, 5'd1, 4'd1, 12'd10}, 1'b1, BAD_DATE},
			'{'{5'd31, 4'd15, 12'd4095, 5'd1, 4'd1, 12'd4095}, 1'b1, BAD_DATE},
			// day 30 of month 12 outside a leap year
			'{'{5'd30, 4'd12, 12'd2, 5'd1, 4'd1, 12'd3}, 1'b1, BAD_DATE},
			'{'{5'd30, 4'd12, 12'd1, 5'd1, 4'd1, 12'd2}, 1'b1, '{21'd2, ORD_EARLIER, 1'b0}},
			'{'{5'd1, 4'd1, 12'd1, 5'd29, 4'd12, 12'd0}, 1'b1, '{21'd2, ORD_LATER, 1'b0}},
			'{'{5'd1, 4'd1, 12'd5, 5'd31, 4'd12, 12'd5}, 1'b1, BAD_DATE},
			'{'{5'd31, 4'd6, 12'd7, 5'd1, 4'd7, 12'd7}, 1'b1, '{21'd2, ORD_EARLIER, 1'b0}},
			'{'{5'd15, 4'd8, 12'd4095, 5'd15, 4'd8, 12'd4095}, 1'b1, '{21'd1, ORD_EQUAL, 1'b0}},
			'{'{5'd29, 4'd12, 12'd4095, 5'd1, 4'd1, 12'd4095}, 1'b0, NOT_TYPED},
			'{'{5'd1, 4'd1, 12'd100, 5'd1, 4'd1, 12'd101}, 1'b0, NOT_TYPED},
			'{'{5'd1, 4'd1, 12'd66, 5'd1, 4'd1, 12'd33}, 1'b0, NOT_TYPED},
			'{'{5'd31, 4'd1, 12'd3000, 5'd30, 4'd11, 12'd3000}, 1'b0, NOT_TYPED},
			'{'{5'd1, 4'd1, 12'd0, 5'd30, 4'd12, 12'd30}, 1'b0, NOT_TYPED},
			// long walk, sets bit 19 of the count
			'{'{5'd1, 4'd1, 12'd0, 5'd1, 4'd1, 12'd1500}, 1'b0, NOT_TYPED}
		};
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int unsigned i = 0; i < DIR_ROWS; i++) begin
			offer(dir_rows[i].pair, dir_rows[i].pinned, dir_rows[i].res);
			pace();
		end
		wait_drained();

		for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
			offer(random_pair(), 1'b0, NOT_TYPED);
			if (i % DRAIN_EVERY == DRAIN_EVERY - 1)
				wait_drained();
			else
				pace();
		end
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("took %0d date pairs (%0d with a bad date), checked %0d results",
			items_taken, invalid_taken, results_checked);
		$display("longest span %0d days, %0d mismatches", longest_span, mismatches);
		if (mismatches == 0 && expected_spans.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
